// ===== hdl/rlum_pkg.sv =====
// Shared types and constants for the recursive lock usage monitor.
// Used by every module of the block but rlum_ram; depends on nothing.
`default_nettype none

package rlum_pkg;

    // Default number of table entries
    localparam int TABLE_DEPTH_DEF = 16;

    // Field widths
    localparam int FUNC_W = 3;
    localparam int OBJ_W  = 32;
    localparam int TAG_W  = 32;

    // Event codes
    localparam logic [FUNC_W-1:0] FN_CREATE  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_LOCK    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_UNLOCK  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DESTROY = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SCAN    = 3'd4;

    // One request
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [OBJ_W-1:0]  object_id;
        logic [TAG_W-1:0]  creation_tag;
    } request_t;

    // One result
    typedef struct packed {
        logic              report_valid;
        logic [OBJ_W-1:0]  report_object;
        logic [TAG_W-1:0]  report_tag;
        logic              table_full;
        logic              last;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic lookup;
        logic destroy_emit;
        logic scan_init;
        logic scan_step;
        logic scan_emit;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_scan;
        logic is_destroy;
        logic pass_done;
        logic found;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/rlum_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rlum_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/rlum_ctrl.sv =====
// Sequencer of the lock usage monitor: steps each request through lookup,
// destroy readout or the ordered final scan. Depends on rlum_pkg.
`default_nettype none

module rlum_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire rlum_pkg::status_t status,
    output rlum_pkg::cmd_t         cmd
);
    import rlum_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_LOOKUP  = 3'd1;
    localparam logic [2:0] ST_DESTROY = 3'd2;
    localparam logic [2:0] ST_SCAN    = 3'd3;
    localparam logic [2:0] ST_EMIT    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                if (status.is_scan)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
                else if (status.is_destroy)
                begin
                    state_next = ST_DESTROY;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DESTROY:
            begin
                cmd.destroy_emit = 1'b1;
                state_next       = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (status.pass_done)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_EMIT:
            begin
                cmd.scan_emit = 1'b1;
                state_next    = status.found ? ST_SCAN : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ===== hdl/rlum_datapath.sv =====
// Datapath of the lock usage monitor: key table with parallel compare, per-entry
// flags, object/tag RAM, scan min-search and result register.
// Depends on rlum_pkg and rlum_ram.
`default_nettype none

module rlum_datapath #(
    parameter int TABLE_DEPTH = rlum_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rlum_pkg::request_t request,
    input  wire rlum_pkg::cmd_t     cmd,
    output rlum_pkg::status_t       status,
    output logic                    result_valid,
    output rlum_pkg::result_t       result
);
    import rlum_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = OBJ_W + TAG_W;
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_DEPTH);

    // Captured request
    logic [FUNC_W-1:0] func_reg;
    logic [OBJ_W-1:0]  obj_reg;
    logic [TAG_W-1:0]  tag_reg;

    // Table flags and keys
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] ever_reg, ever_next;
    logic [TABLE_DEPTH-1:0] held_reg, held_next;
    logic [OBJ_W-1:0]       key_reg [TABLE_DEPTH];

    // Lookup
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free_ok;
    logic [IDX_W-1:0] free_idx;
    logic             ins_we;
    logic             full;

    // Destroy report flag
    logic rep_reg, rep_next;

    // Scan walk
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             found_reg, found_next;
    logic [OBJ_W-1:0] best_obj_reg, best_obj_next;
    logic [TAG_W-1:0] best_tag_reg, best_tag_next;
    logic             have_last_reg, have_last_next;
    logic [OBJ_W-1:0] last_obj_reg, last_obj_next;
    logic             cand;

    // RAM
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;
    logic [OBJ_W-1:0] rd_obj;
    logic [TAG_W-1:0] rd_tag;

    // Result
    result_t res_reg, res_next;
    logic    res_valid_reg, res_valid_next;

    rlum_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ins_we),
        .waddr (free_idx),
        .wdata ({obj_reg, tag_reg}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_obj = ram_rdata[ENT_W-1:TAG_W];
    assign rd_tag = ram_rdata[TAG_W-1:0];

    // Parallel key compare, lowest matching entry
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (key_reg[i] == obj_reg))
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    // Lowest free entry
    always_comb
    begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_ok  = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // Table update per event
    always_comb
    begin
        valid_next = valid_reg;
        ever_next  = ever_reg;
        held_next  = held_reg;
        ins_we     = 1'b0;
        full       = 1'b0;
        rep_next   = rep_reg;
        if (cmd.lookup)
        begin
            case (func_reg)
                FN_CREATE:
                begin
                    if (!hit)
                    begin
                        if (free_ok)
                        begin
                            valid_next[free_idx] = 1'b1;
                            ever_next[free_idx]  = 1'b0;
                            held_next[free_idx]  = 1'b0;
                            ins_we               = 1'b1;
                        end
                        else
                        begin
                            full = 1'b1;
                        end
                    end
                end
                FN_LOCK:
                begin
                    if (hit)
                    begin
                        if (held_reg[hit_idx])
                        begin
                            // real recursion: not a candidate any more
                            valid_next[hit_idx] = 1'b0;
                            ever_next[hit_idx]  = 1'b0;
                            held_next[hit_idx]  = 1'b0;
                        end
                        else
                        begin
                            ever_next[hit_idx] = 1'b1;
                            held_next[hit_idx] = 1'b1;
                        end
                    end
                end
                FN_UNLOCK:
                begin
                    if (hit)
                    begin
                        held_next[hit_idx] = 1'b0;
                    end
                end
                FN_DESTROY:
                begin
                    rep_next = hit && ever_reg[hit_idx];
                    if (hit)
                    begin
                        valid_next[hit_idx] = 1'b0;
                        ever_next[hit_idx]  = 1'b0;
                        held_next[hit_idx]  = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // RAM read: scan walk address, else the matched entry for destroy
    assign ram_raddr = cmd.scan_step ? cnt_reg[IDX_W-1:0] : hit_idx;

    // Scan candidate: ever-locked, and above the last reported object
    assign cand = rd_pend_reg && valid_reg[rd_idx_reg] && ever_reg[rd_idx_reg] &&
                  (!have_last_reg || (rd_obj > last_obj_reg));

    // Scan walk and min search
    always_comb
    begin
        cnt_next       = cnt_reg;
        rd_pend_next   = 1'b0;
        found_next     = found_reg;
        best_obj_next  = best_obj_reg;
        best_tag_next  = best_tag_reg;
        have_last_next = have_last_reg;
        last_obj_next  = last_obj_reg;
        if (cmd.scan_step && (cnt_reg != CNT_END))
        begin
            cnt_next     = cnt_reg + CNT_W'(1);
            rd_pend_next = 1'b1;
        end
        if (cand && (!found_reg || (rd_obj < best_obj_reg)))
        begin
            found_next    = 1'b1;
            best_obj_next = rd_obj;
            best_tag_next = rd_tag;
        end
        if (cmd.scan_init)
        begin
            cnt_next       = '0;
            found_next     = 1'b0;
            have_last_next = 1'b0;
        end
        if (cmd.scan_emit)
        begin
            cnt_next   = '0;
            found_next = 1'b0;
            if (found_reg)
            begin
                have_last_next = 1'b1;
                last_obj_next  = best_obj_reg;
            end
        end
    end

    // Result selection
    always_comb
    begin
        res_valid_next = 1'b0;
        res_next       = res_reg;
        if (cmd.lookup && (func_reg != FN_DESTROY) && (func_reg != FN_SCAN))
        begin
            res_valid_next = 1'b1;
            res_next       = '0;
            res_next.table_full = full;
            res_next.last       = 1'b1;
        end
        if (cmd.destroy_emit)
        begin
            res_valid_next = 1'b1;
            res_next       = '0;
            res_next.last  = 1'b1;
            if (rep_reg)
            begin
                res_next.report_valid  = 1'b1;
                res_next.report_object = rd_obj;
                res_next.report_tag    = rd_tag;
            end
        end
        if (cmd.scan_emit)
        begin
            res_valid_next = 1'b1;
            res_next       = '0;
            if (found_reg)
            begin
                res_next.report_valid  = 1'b1;
                res_next.report_object = best_obj_reg;
                res_next.report_tag    = best_tag_reg;
            end
            else
            begin
                res_next.last = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            ever_reg      <= '0;
            held_reg      <= '0;
            rep_reg       <= 1'b0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            have_last_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            ever_reg      <= ever_next;
            held_reg      <= held_next;
            rep_reg       <= rep_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            found_reg     <= found_next;
            have_last_reg <= have_last_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= request.func;
            obj_reg  <= request.object_id;
            tag_reg  <= request.creation_tag;
        end
        if (ins_we)
        begin
            key_reg[free_idx] <= obj_reg;
        end
        rd_idx_reg   <= cnt_reg[IDX_W-1:0];
        best_obj_reg <= best_obj_next;
        best_tag_reg <= best_tag_next;
        last_obj_reg <= last_obj_next;
        res_reg      <= res_next;
    end

    // Status to controller
    assign status.is_scan    = (func_reg == FN_SCAN);
    assign status.is_destroy = (func_reg == FN_DESTROY);
    assign status.pass_done  = (cnt_reg == CNT_END) && !rd_pend_reg;
    assign status.found      = found_reg;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

// ===== hdl/recursive_lock_usage_monitor.sv =====
// Top level of the recursive lock usage monitor: controller plus datapath.
// Depends on rlum_pkg, rlum_ctrl, rlum_datapath (and through it rlum_ram).
`default_nettype none

// A request is taken when start is high and busy is low. Each result appears
// on result for one cycle with result_valid high; the receiver cannot stall,
// so it must take every strobe. Create, lock, unlock and unknown events are
// accepted, then run one parallel key compare over the table; destroy adds
// a readout step, since the stored object and tag come from a registered RAM
// read. A final scan walks the table once per result, one entry per cycle
// through the RAM read port, picking the smallest object above the last one
// reported; the last result carries last = 1. busy stays high until the final
// result is out.
module recursive_lock_usage_monitor #(
    parameter int TABLE_DEPTH = rlum_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire rlum_pkg::request_t request,
    output logic                    result_valid,
    output rlum_pkg::result_t       result
);
    import rlum_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer
    rlum_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // Table and result datapath
    rlum_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire
